[design/dcc_accessory_packet_decode_macros.svh]
// Assertion macros shared by the accessory packet decoder modules.
`ifndef DCC_ACCESSORY_PACKET_DECODE_MACROS_SVH
`define DCC_ACCESSORY_PACKET_DECODE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define DAP_ASSERT_IMPLY(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dap assertion failed");
`define DAP_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dap assertion failed");
`else
`define DAP_ASSERT_IMPLY(name, clk, rst, ante, cons)
`define DAP_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

[design/dap_pkg.sv]
// Types and constants of the accessory packet decoder.
package dap_pkg;

  localparam int unsigned IN_DATA_W           = 32;
  localparam int unsigned OUT_DATA_W          = 56;
  localparam int unsigned CFG_INDEX_W         = 2;
  localparam int unsigned CFG_DATA_W          = 16;
  localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_MASTER_STYLE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_OWN_FIRST    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_OWN_LAST     = 2'd2;

  // Command-station styles for the address correction.
  localparam logic [1:0] STYLE_STANDARD  = 2'd0;
  localparam logic [1:0] STYLE_COMPENSATE = 2'd1;
  localparam logic [1:0] STYLE_NO_OFFSET  = 2'd2;

  // Result codes.
  localparam logic [1:0] RES_IGNORE  = 2'd0;
  localparam logic [1:0] RES_FOREIGN = 2'd1;
  localparam logic [1:0] RES_OWN     = 2'd2;
  localparam logic [1:0] RES_CV      = 2'd3;

  localparam logic [3:0]  LEN_THREE      = 4'd3;
  localparam logic [3:0]  LEN_FOUR       = 4'd4;
  localparam logic [3:0]  LEN_SIX        = 4'd6;
  localparam logic [8:0]  BROADCAST_RAW  = 9'd511;
  localparam logic [3:0]  CV_PREFIX      = 4'b1110;
  localparam logic [9:0]  COMP_OFFSET    = 10'd64;

  localparam logic [15:0] OWN_ADDR_RESET    = 16'hFFFF;
  localparam logic [15:0] LAST_ADDR_RESET   = 16'hFFFF;
  localparam logic [2:0]  LAST_DEVICE_RESET = 3'd0;
  localparam logic [7:0]  LAST_CMD_RESET    = 8'd0;
  localparam logic [7:0]  LAST_ASPECT_RESET = 8'hFF;

  typedef enum logic [1:0] {
    KIND_BASIC,
    KIND_ASPECT,
    KIND_CV,
    KIND_OTHER
  } len_kind_t;

  typedef struct packed {
    logic [1:0]  master_style;
    logic [15:0] own_first;
    logic [15:0] own_last;
  } dap_cfg_t;

  // One classified packet as it waits between front and back.
  typedef struct packed {
    logic [15:0] addr;
    logic [15:0] oaddr;
    logic [7:0]  cmd;
    logic [7:0]  aspect;
    logic [7:0]  head;
    logic        mine;
    len_kind_t   kind;
    logic        cv_match;
  } dap_item_t;

  localparam int unsigned ITEM_W = $bits(dap_item_t);

endpackage

[design/dap_front.sv]
// Front part: forms the corrected address and classifies one packet.
module dap_front
  import dap_pkg::*;
(
  input  dap_cfg_t    cfg,
  input  logic [7:0]  first_byte,
  input  logic [7:0]  second_byte,
  input  logic [7:0]  third_byte,
  input  logic [3:0]  packet_length,
  output dap_item_t   item
);

  logic [8:0]  raw;
  logic [9:0]  raw_comp;
  logic [15:0] addr;
  logic [2:0]  turnout;
  logic        mine;
  len_kind_t   kind;

  assign raw = {~second_byte[6:4], first_byte[5:0]};

  // The compensated style adds a block of 64 when the low bits are all zero.
  assign raw_comp = (first_byte[5:0] == 6'd0) ? ({1'b0, raw} + COMP_OFFSET) : {1'b0, raw};

  always_comb begin
    case (cfg.master_style)
      STYLE_NO_OFFSET:  addr = {7'd0, raw};
      STYLE_COMPENSATE: addr = {6'd0, raw_comp} - 16'd1;
      default:          addr = {7'd0, raw} - 16'd1;
    endcase
  end

  assign turnout = {1'b0, second_byte[2:1]} + 3'd1;
  assign mine = ((addr >= cfg.own_first) && (addr <= cfg.own_last)) || (raw == BROADCAST_RAW);

  always_comb begin
    case (packet_length)
      LEN_THREE: kind = KIND_BASIC;
      LEN_FOUR:  kind = KIND_ASPECT;
      LEN_SIX:   kind = KIND_CV;
      default:   kind = KIND_OTHER;
    endcase
  end

  always_comb begin
    item.addr     = addr;
    item.oaddr    = {addr[13:0], 2'b00} + {13'd0, turnout};
    item.cmd      = second_byte;
    item.aspect   = third_byte;
    item.head     = (mine && (kind == KIND_ASPECT)) ? third_byte : 8'd0;
    item.mine     = mine;
    item.kind     = kind;
    item.cv_match = (third_byte[7:4] == CV_PREFIX);
  end

endmodule

[design/dap_queue.sv]
// Short first-in first-out queue between front and back.
`include "dcc_accessory_packet_decode_macros.svh"
module dap_queue
  import dap_pkg::*;
#(
  parameter int unsigned WIDTH = ITEM_W,
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             not_empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full      = (count == FULL_COUNT);
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  `DAP_ASSERT_NEXT(a_count_up, clk, rst, do_push && !do_pop, count == $past(count) + CNT_W'(1))
  `DAP_ASSERT_NEXT(a_count_down, clk, rst, do_pop && !do_push, count == $past(count) - CNT_W'(1))

endmodule

[design/dap_back.sv]
// Back part: retransmission filter, last-value state and output register.
`include "dcc_accessory_packet_decode_macros.svh"
module dap_back
  import dap_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  input  dap_item_t             item,
  output logic                  pop,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  logic [15:0] last_address;
  logic [2:0]  last_device;
  logic [7:0]  last_command_byte;
  logic [7:0]  last_aspect_byte;

  logic        same_addr;
  logic        same_cmd;
  logic [1:0]  code_next;
  logic        store_dev;
  logic        store_cmd;
  logic        store_aspect;
  logic [OUT_DATA_W-1:0] tdata_next;

  assign pop       = item_valid && (!m_axis_tvalid || m_axis_tready);
  assign same_addr = (item.addr == last_address);
  assign same_cmd  = (item.cmd == last_command_byte);

  always_comb begin
    code_next    = RES_IGNORE;
    store_dev    = 1'b0;
    store_cmd    = 1'b0;
    store_aspect = 1'b0;
    if (!item.mine) begin
      if (!(same_addr && (item.cmd[2:0] == last_device))) begin
        store_dev = 1'b1;
        code_next = RES_FOREIGN;
      end
    end else begin
      case (item.kind)
        KIND_BASIC: begin
          if (!(same_addr && same_cmd)) begin
            store_cmd = 1'b1;
            code_next = item.cmd[7] ? RES_OWN : RES_IGNORE;
          end
        end
        KIND_ASPECT: begin
          if (!(same_addr && same_cmd && (item.aspect == last_aspect_byte))) begin
            store_cmd    = 1'b1;
            store_aspect = 1'b1;
            code_next    = RES_OWN;
          end
        end
        KIND_CV: begin
          code_next = item.cv_match ? RES_CV : RES_IGNORE;
        end
        default: begin
          code_next = RES_IGNORE;
        end
      endcase
    end
  end

  assign tdata_next = {5'd0, item.head, item.cmd[7], item.cmd[3], item.cmd[2:0],
                       item.cmd[0], {1'b0, item.cmd[2:1]} + 3'd1,
                       item.oaddr, item.addr, code_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      last_address      <= LAST_ADDR_RESET;
      last_device       <= LAST_DEVICE_RESET;
      last_command_byte <= LAST_CMD_RESET;
      last_aspect_byte  <= LAST_ASPECT_RESET;
      m_axis_tvalid     <= 1'b0;
    end else begin
      if (pop) begin
        if (store_dev || store_cmd) begin
          last_address <= item.addr;
        end
        if (store_dev) begin
          last_device <= item.cmd[2:0];
        end
        if (store_cmd) begin
          last_command_byte <= item.cmd;
        end
        if (store_aspect) begin
          last_aspect_byte <= item.aspect;
        end
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      m_axis_tdata <= tdata_next;
    end
  end

  // A foreign packet always leaves its address as the last one seen.
  `DAP_ASSERT_NEXT(a_foreign_last, clk, rst, pop && !item.mine, last_address == $past(item.addr))
  `DAP_ASSERT_IMPLY(a_own_is_mine, clk, rst, pop && (code_next == RES_OWN), item.mine)

endmodule

[design/dcc_accessory_packet_decode.sv]
// Top level of the accessory packet decoder: config registers, front, queue, back.
//
// Decodes one received accessory packet per transfer into one result transfer.
// The block takes one packet every clock cycle while its queue is not full; a
// result passes the queue and then the output register before it appears on
// the master side. The front classifies packets combinationally into a
// QUEUE_DEPTH-entry queue, and the back applies the retransmission filter
// against its last-value registers, one packet per cycle unless the output
// is stalled, into an output register; that single state update per cycle
// sets the rate. Configuration writes take effect in the cycle after the write.
module dcc_accessory_packet_decode
  import dap_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // first_byte, second_byte, third_byte, packet_length, zero fill
  input  logic [IN_DATA_W-1:0]   s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // result_code, decoder_address, output_address, turnout, position, device,
  // activate, is_basic, signal_head, zero fill
  output logic [OUT_DATA_W-1:0]  m_axis_tdata
);

  dap_cfg_t  cfg;
  dap_item_t front_item;
  dap_item_t back_item;
  logic      queue_full;
  logic      queue_valid;
  logic      queue_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.master_style <= STYLE_STANDARD;
      cfg.own_first    <= OWN_ADDR_RESET;
      cfg.own_last     <= OWN_ADDR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MASTER_STYLE: cfg.master_style <= cfg_wdata[1:0];
        CFG_OWN_FIRST:    cfg.own_first    <= cfg_wdata;
        CFG_OWN_LAST:     cfg.own_last     <= cfg_wdata;
        default:          ;
      endcase
    end
  end

  dap_front u_front (
    .cfg           (cfg),
    .first_byte    (s_axis_tdata[7:0]),
    .second_byte   (s_axis_tdata[15:8]),
    .third_byte    (s_axis_tdata[23:16]),
    .packet_length (s_axis_tdata[27:24]),
    .item          (front_item)
  );

  assign s_axis_tready = !queue_full;

  dap_queue #(
    .WIDTH (ITEM_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (s_axis_tvalid),
    .push_data (front_item),
    .full      (queue_full),
    .pop       (queue_pop),
    .pop_data  (back_item),
    .not_empty (queue_valid)
  );

  dap_back u_back (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (queue_valid),
    .item          (back_item),
    .pop           (queue_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

[test/tb_dcc_accessory_packet_decode.sv]
// Self-checking testbench for the accessory packet decoder, with its own decode predictor.
module tb_dcc_accessory_packet_decode;
  import dap_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RAND_PHASES = 12;
  localparam int unsigned PHASE_ITEMS = 150;
  localparam int unsigned SHOWN_MAX   = 10;

  typedef struct packed {
    logic [1:0]  code;
    logic [15:0] dec_addr;
    logic [15:0] out_addr;
    logic [2:0]  turnout;
    logic        position;
    logic [2:0]  device;
    logic        activate;
    logic        is_basic;
    logic [7:0]  head;
  } dap_result_t;

  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [3:0] len;
  } packet_t;

  typedef struct {
    bit                     is_cfg;
    logic [CFG_INDEX_W-1:0] idx;
    logic [CFG_DATA_W-1:0]  val;
    packet_t                pkt;
    bit                     typed;
    dap_result_t            res;
  } plan_row_t;

  typedef struct {
    bit          typed;
    dap_result_t res;
  } typed_note_t;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // first_byte, second_byte, third_byte, packet_length, zero fill
  logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // result_code, decoder_address, output_address, turnout, position, device,
  // activate, is_basic, signal_head, zero fill
  logic [OUT_DATA_W-1:0]  m_axis_tdata;

  // Predictor copy of the configuration and of the retransmission filter.
  logic [1:0]  style_q     = STYLE_STANDARD;
  logic [15:0] own_lo      = OWN_ADDR_RESET;
  logic [15:0] own_hi      = OWN_ADDR_RESET;
  logic [15:0] seen_addr   = LAST_ADDR_RESET;
  logic [2:0]  seen_device = LAST_DEVICE_RESET;
  logic [7:0]  seen_cmd    = LAST_CMD_RESET;
  logic [7:0]  seen_aspect = LAST_ASPECT_RESET;

  dap_result_t want_q[$];
  typed_note_t notes[$];
  int          faults = 0;
  int          results_taken = 0;

  dcc_accessory_packet_decode u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("CHECK FAILED");
    $finish;
  end

  // Decodes one packet and advances the retransmission filter.
  function automatic dap_result_t decode_accessory(packet_t p);
    logic [8:0]  raw;
    logic [15:0] addr;
    logic        mine;
    dap_result_t r;
    // The high address bits travel inverted in the second byte.
    raw = {~p.b1[6:4], p.b0[5:0]};
    case (style_q)
      STYLE_NO_OFFSET: addr = {7'd0, raw};
      STYLE_COMPENSATE: begin
        addr = {7'd0, raw} - 16'd1;
        if (p.b0[5:0] == 6'd0) addr = addr + 16'(COMP_OFFSET);
      end
      default: addr = {7'd0, raw} - 16'd1;
    endcase
    r.code     = RES_IGNORE;
    r.dec_addr = addr;
    r.turnout  = {1'b0, p.b1[2:1]} + 3'd1;
    r.out_addr = {addr[13:0], 2'b00} + {13'd0, r.turnout};
    r.position = p.b1[0];
    r.device   = p.b1[2:0];
    r.activate = p.b1[3];
    r.is_basic = p.b1[7];
    r.head     = 8'd0;
    mine = (addr >= own_lo && addr <= own_hi) || raw == BROADCAST_RAW;
    if (!mine) begin
      if (!(addr == seen_addr && r.device == seen_device)) begin
        seen_addr   = addr;
        seen_device = r.device;
        r.code      = RES_FOREIGN;
      end
    end else if (p.len == LEN_THREE) begin
      if (!(addr == seen_addr && p.b1 == seen_cmd)) begin
        seen_addr = addr;
        seen_cmd  = p.b1;
        r.code    = p.b1[7] ? RES_OWN : RES_IGNORE;
      end
    end else if (p.len == LEN_FOUR) begin
      r.head = p.b2;
      if (!(addr == seen_addr && p.b1 == seen_cmd && p.b2 == seen_aspect)) begin
        seen_addr   = addr;
        seen_cmd    = p.b1;
        seen_aspect = p.b2;
        r.code      = RES_OWN;
      end
    end else if (p.len == LEN_SIX && p.b2[7:4] == CV_PREFIX) begin
      r.code = RES_CV;
    end
    return r;
  endfunction

  function automatic string describe(dap_result_t r);
    return $sformatf({"code=%0d addr=%0d oaddr=%0d turnout=%0d pos=%0d dev=%0d",
                      " act=%0d basic=%0d head=%02h"},
                     r.code, r.dec_addr, r.out_addr, r.turnout, r.position, r.device,
                     r.activate, r.is_basic, r.head);
  endfunction

  // Checking comes before the new expectation so that a same-edge result never
  // sees an item accepted at that very edge.
  always @(posedge clk) begin : scoreboard
    dap_result_t got;
    dap_result_t want;
    dap_result_t pred;
    typed_note_t note;
    packet_t     p;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.code     = m_axis_tdata[1:0];
      got.dec_addr = m_axis_tdata[17:2];
      got.out_addr = m_axis_tdata[33:18];
      got.turnout  = m_axis_tdata[36:34];
      got.position = m_axis_tdata[37];
      got.device   = m_axis_tdata[40:38];
      got.activate = m_axis_tdata[41];
      got.is_basic = m_axis_tdata[42];
      got.head     = m_axis_tdata[50:43];
      if (want_q.size() == 0) begin
        faults++;
        if (faults <= SHOWN_MAX) $display("unexpected result: %s", describe(got));
      end else begin
        want = want_q.pop_front();
        if (got.code !== want.code || got.dec_addr !== want.dec_addr ||
            got.out_addr !== want.out_addr || got.turnout !== want.turnout ||
            got.position !== want.position || got.device !== want.device ||
            got.activate !== want.activate || got.is_basic !== want.is_basic ||
            got.head !== want.head) begin
          faults++;
          if (faults <= SHOWN_MAX) begin
            $display("mismatch: expected %s", describe(want));
            $display("          actual   %s", describe(got));
          end
        end
      end
    end
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      p.b0  = s_axis_tdata[7:0];
      p.b1  = s_axis_tdata[15:8];
      p.b2  = s_axis_tdata[23:16];
      p.len = s_axis_tdata[27:24];
      pred  = decode_accessory(p);
      note.typed = 1'b0;
      if (notes.size() != 0) note = notes.pop_front();
      want_q.push_back(note.typed ? note.res : pred);
    end
  end

  // Result side: random stalls, calm stretches, and two long hold-offs that
  // back the block up into its input.
  initial begin : receiver
    int stall;
    bit calm;
    calm = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (results_taken % 50 == 0) calm = ($urandom_range(0, 2) == 0);
      if (results_taken == 400 || results_taken == 1300) stall = 64;
      else stall = calm ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        @(negedge clk);
        m_axis_tready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      results_taken++;
    end
  end

  function automatic packet_t pk(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                                 logic [3:0] len);
    packet_t p;
    p.b0  = b0;
    p.b1  = b1;
    p.b2  = b2;
    p.len = len;
    return p;
  endfunction

  function automatic dap_result_t res(logic [1:0] code, logic [15:0] dec_addr,
                                      logic [15:0] out_addr, logic [2:0] turnout,
                                      logic position, logic [2:0] device, logic activate,
                                      logic is_basic, logic [7:0] head);
    dap_result_t r;
    r.code     = code;
    r.dec_addr = dec_addr;
    r.out_addr = out_addr;
    r.turnout  = turnout;
    r.position = position;
    r.device   = device;
    r.activate = activate;
    r.is_basic = is_basic;
    r.head     = head;
    return r;
  endfunction

  function automatic plan_row_t pkt_row(packet_t p);
    plan_row_t row;
    row.is_cfg = 1'b0;
    row.idx    = '0;
    row.val    = '0;
    row.pkt    = p;
    row.typed  = 1'b0;
    row.res    = '0;
    return row;
  endfunction

  function automatic plan_row_t typed_row(packet_t p, dap_result_t r);
    plan_row_t row;
    row       = pkt_row(p);
    row.typed = 1'b1;
    row.res   = r;
    return row;
  endfunction

  function automatic plan_row_t cfg_row(logic [CFG_INDEX_W-1:0] idx,
                                        logic [CFG_DATA_W-1:0] val);
    plan_row_t row;
    row        = pkt_row('0);
    row.is_cfg = 1'b1;
    row.idx    = idx;
    row.val    = val;
    return row;
  endfunction

  // Drops valid and waits until every expected result has come back.
  task automatic drain();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (want_q.size() != 0) @(negedge clk);
  endtask

  task automatic cfg_write(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_MASTER_STYLE: style_q = val[1:0];
      CFG_OWN_FIRST:    own_lo  = val;
      CFG_OWN_LAST:     own_hi  = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Offers one packet after a gap and returns at the edge of its transfer.
  task automatic send(packet_t p, bit typed, dap_result_t r, int gap);
    if (gap > 0) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    notes.push_back('{typed, r});
    s_axis_tdata  <= {4'd0, p.len, p.b2, p.b1, p.b0};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  initial begin : stimulus
    plan_row_t   plan[$];
    packet_t     pkt;
    packet_t     prev;
    bit          have_prev;
    bit          calm;
    int          r;
    logic [15:0] lo;
    logic [15:0] hi;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset configuration answers only to 65535, which raw address zero gives, and to broadcast.
    plan.push_back(typed_row(pk(8'h00, 8'hF0, 8'h00, LEN_THREE),
                             res(RES_OWN, 16'hFFFF, 16'hFFFD, 3'd1, 1'b0, 3'd0, 1'b0,
                                 1'b1, 8'h00)));
    plan.push_back(typed_row(pk(8'h00, 8'hF0, 8'h00, LEN_THREE),
                             res(RES_IGNORE, 16'hFFFF, 16'hFFFD, 3'd1, 1'b0, 3'd0, 1'b0,
                                 1'b1, 8'h00)));
    // Broadcast (raw 511) with every command bit set.
    plan.push_back(typed_row(pk(8'h3F, 8'h8F, 8'h00, LEN_THREE),
                             res(RES_OWN, 16'd510, 16'd2044, 3'd4, 1'b1, 3'd7, 1'b1,
                                 1'b1, 8'h00)));
    plan.push_back(typed_row(pk(8'hFF, 8'h0F, 8'hAB, LEN_FOUR),
                             res(RES_OWN, 16'd510, 16'd2044, 3'd4, 1'b1, 3'd7, 1'b1,
                                 1'b0, 8'hAB)));
    plan.push_back(typed_row(pk(8'hFF, 8'h0F, 8'hAB, LEN_FOUR),
                             res(RES_IGNORE, 16'd510, 16'd2044, 3'd4, 1'b1, 3'd7, 1'b1,
                                 1'b0, 8'hAB)));
    plan.push_back(typed_row(pk(8'h3F, 8'h0F, 8'hE5, LEN_SIX),
                             res(RES_CV, 16'd510, 16'd2044, 3'd4, 1'b1, 3'd7, 1'b1,
                                 1'b0, 8'h00)));
    plan.push_back(typed_row(pk(8'h3F, 8'h0F, 8'hF5, LEN_SIX),
                             res(RES_IGNORE, 16'd510, 16'd2044, 3'd4, 1'b1, 3'd7, 1'b1,
                                 1'b0, 8'h00)));
    plan.push_back(typed_row(pk(8'h3F, 8'h0F, 8'hE5, 4'd0),
                             res(RES_IGNORE, 16'd510, 16'd2044, 3'd4, 1'b1, 3'd7, 1'b1,
                                 1'b0, 8'h00)));
    plan.push_back(typed_row(pk(8'h3F, 8'h0F, 8'hE5, 4'd15),
                             res(RES_IGNORE, 16'd510, 16'd2044, 3'd4, 1'b1, 3'd7, 1'b1,
                                 1'b0, 8'h00)));
    // Foreign addresses: a repeat with the same device is suppressed.
    plan.push_back(typed_row(pk(8'h01, 8'hF0, 8'h00, LEN_THREE),
                             res(RES_FOREIGN, 16'd0, 16'd1, 3'd1, 1'b0, 3'd0, 1'b0,
                                 1'b1, 8'h00)));
    plan.push_back(typed_row(pk(8'h01, 8'hF0, 8'h5A, LEN_FOUR),
                             res(RES_IGNORE, 16'd0, 16'd1, 3'd1, 1'b0, 3'd0, 1'b0,
                                 1'b1, 8'h00)));
    plan.push_back(typed_row(pk(8'h01, 8'hF1, 8'h00, LEN_THREE),
                             res(RES_FOREIGN, 16'd0, 16'd1, 3'd1, 1'b1, 3'd1, 1'b0,
                                 1'b1, 8'h00)));
    // Extended command of length three stores state but reports nothing.
    plan.push_back(pkt_row(pk(8'h00, 8'h70, 8'h00, LEN_THREE)));
    plan.push_back(pkt_row(pk(8'h00, 8'h70, 8'h00, LEN_THREE)));
    plan.push_back(cfg_row(CFG_MASTER_STYLE, {14'd0, STYLE_NO_OFFSET}));
    plan.push_back(cfg_row(CFG_OWN_FIRST, 16'd0));
    plan.push_back(cfg_row(CFG_OWN_LAST, 16'hFFFF));
    plan.push_back(pkt_row(pk(8'h00, 8'hF8, 8'h00, LEN_THREE)));
    plan.push_back(pkt_row(pk(8'hFF, 8'h80, 8'h00, LEN_FOUR)));
    plan.push_back(pkt_row(pk(8'hFF, 8'h80, 8'h00, LEN_FOUR)));
    plan.push_back(pkt_row(pk(8'h2A, 8'hD5, 8'hE0, LEN_SIX)));
    // Compensated style: zero low bits pull the address up by 64.
    plan.push_back(cfg_row(CFG_MASTER_STYLE, {14'd0, STYLE_COMPENSATE}));
    plan.push_back(cfg_row(CFG_OWN_FIRST, 16'd64));
    plan.push_back(cfg_row(CFG_OWN_LAST, 16'd127));
    plan.push_back(pkt_row(pk(8'h00, 8'hE8, 8'h00, LEN_THREE)));
    plan.push_back(pkt_row(pk(8'h01, 8'hE8, 8'h00, LEN_THREE)));
    plan.push_back(pkt_row(pk(8'h00, 8'hF8, 8'h00, LEN_THREE)));
    plan.push_back(pkt_row(pk(8'h40, 8'hC9, 8'h12, LEN_FOUR)));
    // Unused style code with an empty range: only broadcast is own.
    plan.push_back(cfg_row(CFG_MASTER_STYLE, 16'd3));
    plan.push_back(cfg_row(CFG_OWN_FIRST, 16'd100));
    plan.push_back(cfg_row(CFG_OWN_LAST, 16'd50));
    plan.push_back(pkt_row(pk(8'h05, 8'h99, 8'h00, LEN_THREE)));
    plan.push_back(pkt_row(pk(8'h3F, 8'h0E, 8'h77, LEN_FOUR)));

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        drain();
        cfg_write(plan[i].idx, plan[i].val);
      end else begin
        send(plan[i].pkt, plan[i].typed, plan[i].res, $urandom_range(0, 7));
      end
    end

    // Random phases: repeated packets, as a command station sends them, mixed
    // with a majority of fresh ones over the whole field space.
    have_prev = 1'b0;
    prev      = '0;
    for (int p = 0; p < RAND_PHASES; p++) begin
      drain();
      cfg_write(CFG_MASTER_STYLE, (p < 4) ? 16'(p) : 16'($urandom_range(0, 3)));
      case (p % 6)
        0: begin lo = 16'd0;     hi = 16'hFFFF; end
        1: begin lo = 16'hFFFF;  hi = 16'hFFFF; end
        2: begin
          lo = 16'($urandom_range(200, 520));
          hi = lo - 16'($urandom_range(1, 200));
        end
        3: begin lo = 16'd0;     hi = 16'd0; end
        default: begin
          lo = 16'($urandom_range(0, 400));
          hi = lo + 16'($urandom_range(0, 200));
        end
      endcase
      cfg_write(CFG_OWN_FIRST, lo);
      cfg_write(CFG_OWN_LAST, hi);
      calm = (p % 3 == 0);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        r = $urandom_range(0, 99);
        if (have_prev && r < 35) begin
          pkt = prev;
        end else if (have_prev && r < 45) begin
          pkt    = prev;
          pkt.b2 = 8'($urandom);
        end else begin
          pkt.b0 = 8'($urandom);
          pkt.b1 = 8'($urandom);
          pkt.b2 = 8'($urandom);
          r = $urandom_range(0, 99);
          if (r < 40) pkt.len = LEN_THREE;
          else if (r < 65) pkt.len = LEN_FOUR;
          else if (r < 80) begin
            pkt.len = LEN_SIX;
            if ($urandom_range(0, 1) == 1) pkt.b2[7:4] = CV_PREFIX;
          end else pkt.len = 4'($urandom_range(0, 15));
        end
        prev      = pkt;
        have_prev = 1'b1;
        if ($urandom_range(0, 199) == 0) drain();
        send(pkt, 1'b0, '0, calm ? 0 : $urandom_range(0, 7));
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (want_q.size() != 0) begin
      faults++;
      $display("%0d expected results never arrived", want_q.size());
    end
    if (faults == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
